### rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants for the binary sequence autocorrelator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    // default store depth
    localparam int MAX_LEN_DEF = 64;

    // fixed field widths of the result and input items
    localparam int IDX_W      = 6;
    localparam int CORR_W     = 8;
    localparam int M_TDATA_W  = 16;
    localparam int M_PAD_W    = M_TDATA_W - IDX_W - CORR_W;
    localparam int S_TDATA_W  = 8;

    // correlation modes
    localparam logic MODE_PERIODIC  = 1'b0;
    localparam logic MODE_APERIODIC = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    // accumulator control from the sequencer
    typedef struct packed {
        logic clr;
        logic en;
    } acc_ctrl_t;

endpackage

### rtl/bsa_store.sv
// ----------------------------------------------------------------------------
// bsa_store
// One-bit sequence store, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bsa_store #(
    parameter int DEPTH = bsa_pkg::MAX_LEN_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic          rd_data_a,
    output logic          rd_data_b
);

    logic mem [DEPTH];
    logic rd_a_reg;
    logic rd_b_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered reads
    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

### rtl/bsa_corr_acc.sv
// ----------------------------------------------------------------------------
// bsa_corr_acc
// Serial correlation accumulator, one element product per cycle while enabled.
// ----------------------------------------------------------------------------
module bsa_corr_acc (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bsa_pkg::acc_ctrl_t                ctrl,
    input  logic                              bit_a,
    input  logic                              bit_b,
    output logic signed [bsa_pkg::CORR_W-1:0] acc
);
    import bsa_pkg::*;

    logic signed [CORR_W-1:0] acc_reg;
    logic signed [CORR_W-1:0] acc_next;
    logic signed [CORR_W-1:0] term;

    // equal bits give +1, different bits give -1
    assign term = (bit_a == bit_b) ? CORR_W'(1) : -CORR_W'(1);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.en)
        begin
            acc_next = acc_reg + term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

### rtl/binary_sequence_autocorrelator_top.sv
// ----------------------------------------------------------------------------
// binary_sequence_autocorrelator_top
// Loads a +/-1 sequence one bit per item, then emits C(tau) for tau 0..N-1.
// ----------------------------------------------------------------------------
// load: one input item per cycle; the closing item starts the correlation pass
// shift 0 result (value N) is registered from the emit state entered after the closing item
// each further shift reads L store pairs in the run state, L = N (periodic) or N-tau (aperiodic),
// then passes drain and emit; the walk is serial over the store's two read ports and the accumulator
// input is refused from the closing item until the last result is registered
// rst_n clears the sequencer, load count, mode and output valid; store keeps data
module binary_sequence_autocorrelator_top #(
    parameter int MAX_LEN = bsa_pkg::MAX_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: correlation_mode
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bsa_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] seq_bit
    input  logic                            s_tlast,   // is_last
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bsa_pkg::M_TDATA_W-1:0]   m_tdata,   // [5:0] shift_index, [13:6] corr_value
    output logic                            m_tlast    // last_value
);
    import bsa_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    state_t                   state_reg, state_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            n_reg, n_next;
    logic [AW-1:0]            tau_reg, tau_next;
    logic [AW-1:0]            f_reg, f_next;
    logic [AW-1:0]            g_reg, g_next;
    logic                     mode_reg, mode_next;
    logic                     run_mode_reg, run_mode_next;
    logic                     pv_reg, pv_next;
    logic                     m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [CORR_W-1:0]        corr_reg, corr_next;
    logic                     lastv_reg, lastv_next;

    logic                     s_acc;
    logic [CW-1:0]            cnt_inc;
    logic [CW-1:0]            n_m1;
    logic [AW-1:0]            tau_inc;
    logic [CW-1:0]            g_start;
    logic                     out_free;
    logic                     rd_a, rd_b;
    logic signed [CORR_W-1:0] acc;
    acc_ctrl_t                acc_ctrl;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_acc    = s_tvalid && s_tready;
    assign cnt_inc  = cnt_reg + CW'(1);
    assign n_m1     = n_reg - CW'(1);
    assign tau_inc  = tau_reg + AW'(1);
    assign g_start  = n_reg - CW'(tau_inc);
    assign out_free = !m_valid_reg || m_tready;

    // sequence store
    bsa_store #(
        .DEPTH(MAX_LEN)
    ) u_store (
        .clk      (clk),
        .wr_en    (s_acc),
        .wr_addr  (cnt_reg[AW-1:0]),
        .wr_data  (s_tdata[0]),
        .rd_addr_a(f_reg),
        .rd_addr_b(g_reg),
        .rd_data_a(rd_a),
        .rd_data_b(rd_b)
    );

    // serial accumulator
    bsa_corr_acc u_acc (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (acc_ctrl),
        .bit_a(rd_a),
        .bit_b(rd_b),
        .acc  (acc)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        tau_next      = tau_reg;
        f_next        = f_reg;
        g_next        = g_reg;
        mode_next     = cfg_wr_en ? cfg_wr_data : mode_reg;
        run_mode_next = run_mode_reg;
        pv_next       = 1'b0;
        m_valid_next  = m_valid_reg && !m_tready;
        idx_next      = idx_reg;
        corr_next     = corr_reg;
        lastv_next    = lastv_reg;
        acc_ctrl.clr  = 1'b0;
        acc_ctrl.en   = pv_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_acc)
                begin
                    cnt_next = cnt_inc;
                    if (s_tlast || (cnt_inc == CW'(MAX_LEN)))
                    begin
                        n_next        = cnt_inc;
                        cnt_next      = '0;
                        tau_next      = '0;
                        run_mode_next = mode_reg;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_RUN:
            begin
                // issue one pair of store reads per cycle
                pv_next = 1'b1;
                if (CW'(f_reg) == n_m1)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    f_next = f_reg + AW'(1);
                    g_next = (CW'(g_reg) == n_m1) ? '0 : g_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                // last product lands in the accumulator this cycle
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    idx_next     = IDX_W'(tau_reg);
                    corr_next    = (tau_reg == '0) ? CORR_W'(n_reg) : acc;
                    lastv_next   = (CW'(tau_reg) == n_m1);
                    if (CW'(tau_reg) == n_m1)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        // set up the walk for the next shift
                        tau_next     = tau_inc;
                        acc_ctrl.clr = 1'b1;
                        state_next   = ST_RUN;
                        if (run_mode_reg == MODE_PERIODIC)
                        begin
                            f_next = '0;
                            g_next = g_start[AW-1:0];
                        end
                        else
                        begin
                            f_next = tau_inc;
                            g_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            mode_reg     <= MODE_PERIODIC;
            pv_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            mode_reg     <= mode_next;
            pv_reg       <= pv_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        tau_reg      <= tau_next;
        f_reg        <= f_next;
        g_reg        <= g_next;
        run_mode_reg <= run_mode_next;
        idx_reg      <= idx_next;
        corr_reg     <= corr_next;
        lastv_reg    <= lastv_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, corr_reg, idx_reg};
    assign m_tlast  = lastv_reg;

endmodule

### rtl/bsa_checker.sv
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks for the binary sequence autocorrelator.
// ----------------------------------------------------------------------------
module bsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a result item holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result item dropped while stalled");

    // a closing item starts the correlation pass, so loading stops
    a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input accepted right after closing item");

    // shift zero is the sequence length, positive and at most 64
    a_zero_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[5:0] == 6'd0)) |->
        (!m_tdata[13] && (m_tdata[13:6] != 8'd0) && (m_tdata[13:6] <= 8'd64)))
        else $error("bad zero-shift value");

    // a run that ends at shift zero has length one
    a_len_one: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && (m_tdata[5:0] == 6'd0)) |-> (m_tdata[13:6] == 8'd1))
        else $error("single-element run with wrong value");

endmodule

bind binary_sequence_autocorrelator_top bsa_checker u_bsa_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
